[rtl/des_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// des_pkg: shared types, tables and helpers for the des block cipher
// permutation tables (lsb-first bit numbering), s-boxes and round function
// ----------------------------------------------------------------------------
package des_pkg;

  localparam int NumRounds = 16;
  localparam int HalfKeyW  = 28;
  localparam int RoundKeyW = 48;
  localparam int Pc1W      = 56;

  localparam logic [1:0] CFG_IDX_KEY  = 2'd0;
  localparam logic [1:0] CFG_IDX_MODE = 2'd1;

  typedef logic [63:0] block_t;
  typedef logic [RoundKeyW-1:0] rkey_t;
  typedef logic [31:0] half_t;

  typedef logic [6:0] tab64_t [64];
  typedef logic [6:0] tab48_t [48];
  typedef logic [6:0] tab32_t [32];
  typedef logic [6:0] tab56_t [56];
  typedef logic [3:0] sbox_t [8][64];

  localparam tab64_t T_IP = '{
    58,50,42,34,26,18,10,2,60,52,44,36,28,20,12,4,62,54,46,38,30,22,14,6,
    64,56,48,40,32,24,16,8,57,49,41,33,25,17,9,1,59,51,43,35,27,19,11,3,
    61,53,45,37,29,21,13,5,63,55,47,39,31,23,15,7};
  localparam tab64_t T_IPINV = '{
    40,8,48,16,56,24,64,32,39,7,47,15,55,23,63,31,38,6,46,14,54,22,62,30,
    37,5,45,13,53,21,61,29,36,4,44,12,52,20,60,28,35,3,43,11,51,19,59,27,
    34,2,42,10,50,18,58,26,33,1,41,9,49,17,57,25};
  localparam tab48_t T_EXP = '{
    32,1,2,3,4,5,4,5,6,7,8,9,8,9,10,11,12,13,12,13,14,15,16,17,
    16,17,18,19,20,21,20,21,22,23,24,25,24,25,26,27,28,29,28,29,30,31,32,1};
  localparam tab32_t T_PERM = '{
    16,7,20,21,29,12,28,17,1,15,23,26,5,18,31,10,
    2,8,24,14,32,27,3,9,19,13,30,6,22,11,4,25};
  localparam tab56_t T_PC1 = '{
    57,49,41,33,25,17,9,1,58,50,42,34,26,18,10,2,59,51,43,35,27,19,11,3,
    60,52,44,36,63,55,47,39,31,23,15,7,62,54,46,38,30,22,14,6,
    61,53,45,37,29,21,13,5,28,20,12,4};
  localparam tab48_t T_PC2 = '{
    14,17,11,24,1,5,3,28,15,6,21,10,23,19,12,4,26,8,16,7,27,20,13,2,
    41,52,31,37,47,55,30,40,51,45,33,48,44,49,39,56,34,53,46,42,50,36,29,32};
  localparam logic [1:0] T_ROT [16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};

  // s-box entries flattened as row*16 + col
  localparam sbox_t T_SBOX = '{
    '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7,0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
      4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0,15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
    '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10,3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
      0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15,13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
    '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8,13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
      13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7,1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
    '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15,13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
      10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4,3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
    '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9,14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
      4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14,11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
    '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11,10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
      9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6,4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
    '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1,13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
      1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2,6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
    '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7,1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
      7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8,2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

  function automatic block_t perm_ip(block_t v);
    block_t r;
    for (int i = 0; i < 64; i++) r[i] = v[6'(T_IP[i] - 7'd1)];
    return r;
  endfunction

  function automatic block_t perm_ipinv(block_t v);
    block_t r;
    for (int i = 0; i < 64; i++) r[i] = v[6'(T_IPINV[i] - 7'd1)];
    return r;
  endfunction

  function automatic logic [Pc1W-1:0] perm_pc1(block_t v);
    logic [Pc1W-1:0] r;
    for (int i = 0; i < Pc1W; i++) r[i] = v[6'(T_PC1[i] - 7'd1)];
    return r;
  endfunction

  function automatic rkey_t perm_pc2(logic [Pc1W-1:0] v);
    rkey_t r;
    for (int i = 0; i < RoundKeyW; i++) r[i] = v[6'(T_PC2[i] - 7'd1)];
    return r;
  endfunction

  // right rotate of a 28-bit half
  function automatic logic [HalfKeyW-1:0] rot28(logic [HalfKeyW-1:0] h, logic [1:0] n);
    logic [HalfKeyW-1:0] r;
    r = (n == 2'd1) ? {h[0], h[HalfKeyW-1:1]} : {h[1:0], h[HalfKeyW-1:2]};
    return r;
  endfunction

  function automatic half_t feistel(half_t h, rkey_t k);
    rkey_t x;
    half_t s;
    half_t r;
    logic [5:0] g;
    logic [5:0] a;
    for (int i = 0; i < RoundKeyW; i++) x[i] = h[5'(T_EXP[i] - 7'd1)];
    x = x ^ k;
    for (int i = 0; i < 8; i++) begin
      g = x[6*i +: 6];
      a = {g[0], g[5], g[1], g[2], g[3], g[4]};
      s[4*i +: 4] = T_SBOX[i][a];
    end
    for (int i = 0; i < 32; i++) r[i] = s[5'(T_PERM[i] - 7'd1)];
    return r;
  endfunction

endpackage

[rtl/des_round.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// des_round: one registered feistel round stage
// encrypt and decrypt directions, stall-aware valid/data register
// ----------------------------------------------------------------------------
module des_round (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  logic              vld_in,
  input  logic              dec_in,
  input  des_pkg::half_t    l_in,
  input  des_pkg::half_t    r_in,
  input  des_pkg::rkey_t    rkey,
  output logic              vld_out,
  output logic              dec_out,
  output des_pkg::half_t    l_out,
  output des_pkg::half_t    r_out
);

  logic           vld_r;
  logic           dec_r;
  des_pkg::half_t l_r, r_r, l_nxt, r_nxt;

  always_comb begin
    if (dec_in) begin
      l_nxt = des_pkg::feistel(l_in, rkey) ^ r_in;
      r_nxt = l_in;
    end else begin
      l_nxt = r_in;
      r_nxt = des_pkg::feistel(r_in, rkey) ^ l_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (advance) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      dec_r <= dec_in;
      l_r   <= l_nxt;
      r_r   <= r_nxt;
    end
  end

  assign vld_out = vld_r;
  assign dec_out = dec_r;
  assign l_out   = l_r;
  assign r_out   = r_r;

endmodule

[rtl/des_block_cipher.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// des_block_cipher: pipelined des ecb encrypt/decrypt
// sixteen unrolled feistel rounds, while not stalled one 64-bit block per cycle
// ----------------------------------------------------------------------------
// The core accepts one block every cycle while the output is not stalled. A
// block accepted at an edge passes through the initial permutation register,
// the round registers and the output register before it is presented. The 18
// register stages are one for the initial permutation, one per feistel round
// (16), and the output register that holds the inverse permutation. The whole
// pipeline freezes while a result waits at the output under stall, so nothing
// is lost or repeated. Round keys are held in registers and are loaded with
// the new schedule at the edge of the cipher_key write itself; the user must
// change configuration only while the pipeline is empty; the block does not enforce it.
module des_block_cipher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_block_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_block_out,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int NR = des_pkg::NumRounds;
  localparam int HK = des_pkg::HalfKeyW;

  // config registers
  logic                    dec_mode_r;
  des_pkg::rkey_t          rkeys_r [NR];
  des_pkg::rkey_t          rkeys_nxt [NR];

  // pipeline advances unless the output register holds a stalled transaction
  logic advance;
  assign advance  = !(out_valid && out_stall);
  assign in_stall = !advance;
  assign cfg_ready = 1'b1;

  // key schedule, rebuilt on a cipher_key write
  always_comb begin
    logic [des_pkg::Pc1W-1:0] k;
    logic [HK-1:0] lo, hi;
    k  = des_pkg::perm_pc1(cfg_data);
    lo = k[HK-1:0];
    hi = k[2*HK-1:HK];
    for (int i = 0; i < NR; i++) begin
      lo = des_pkg::rot28(lo, des_pkg::T_ROT[i]);
      hi = des_pkg::rot28(hi, des_pkg::T_ROT[i]);
      rkeys_nxt[i] = des_pkg::perm_pc2({hi, lo});
    end
  end

  // reset schedule of key zero is all zero words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_mode_r <= 1'b0;
      for (int i = 0; i < NR; i++) rkeys_r[i] <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        des_pkg::CFG_IDX_KEY: begin
          for (int i = 0; i < NR; i++) rkeys_r[i] <= rkeys_nxt[i];
        end
        des_pkg::CFG_IDX_MODE: begin
          dec_mode_r <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  // stage 0: initial permutation
  logic           s0_vld_r;
  logic           s0_dec_r;
  des_pkg::block_t s0_blk_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (advance) begin
      s0_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s0_dec_r <= dec_mode_r;
      s0_blk_r <= des_pkg::perm_ip(in_block_in);
    end
  end

  // round chain; stage i holds the state after i rounds
  logic           vld_c [NR+1];
  logic           dec_c [NR+1];
  des_pkg::half_t l_c   [NR+1];
  des_pkg::half_t r_c   [NR+1];

  assign vld_c[0] = s0_vld_r;
  assign dec_c[0] = s0_dec_r;
  assign l_c[0]   = s0_blk_r[31:0];
  assign r_c[0]   = s0_blk_r[63:32];

  for (genvar g = 0; g < NR; g++) begin : g_round
    // encrypt walks keys forward, decrypt walks them backward
    des_pkg::rkey_t rk;
    assign rk = dec_c[g] ? rkeys_r[NR-1-g] : rkeys_r[g];
    des_round u_round (
      .clk     (clk),
      .rst_n   (rst_n),
      .advance (advance),
      .vld_in  (vld_c[g]),
      .dec_in  (dec_c[g]),
      .l_in    (l_c[g]),
      .r_in    (r_c[g]),
      .rkey    (rk),
      .vld_out (vld_c[g+1]),
      .dec_out (dec_c[g+1]),
      .l_out   (l_c[g+1]),
      .r_out   (r_c[g+1])
    );
  end

  // output register with inverse permutation
  logic            out_vld_r;
  des_pkg::block_t out_blk_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= vld_c[NR];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_blk_r <= des_pkg::perm_ipinv({r_c[NR], l_c[NR]});
    end
  end

  assign out_valid     = out_vld_r;
  assign out_block_out = out_blk_r;

  // a stalled result holds its data
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_block_out))
    else $error("stalled result changed");

  // an accepted transaction enters stage 0
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> s0_vld_r)
    else $error("accepted transaction lost");

  // a transaction in the last round reaches the output when the pipe moves
  a_exit: assert property (@(posedge clk) disable iff (!rst_n)
    vld_c[NR] && advance |=> out_valid)
    else $error("transaction dropped at output");

endmodule
